// ===== sv/dpr_pkg.sv =====
// shared types and constants for the duotone pixel recolor block
// no dependencies
package dpr_pkg;

	localparam int unsigned CHAN_W = 8;
	localparam int unsigned PROD_W = 17;
	localparam int unsigned NUM_W  = 16;
	localparam int unsigned IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_FORE_RED   = 3'd0;
	localparam logic [IDX_W-1:0] REG_FORE_GREEN = 3'd1;
	localparam logic [IDX_W-1:0] REG_FORE_BLUE  = 3'd2;
	localparam logic [IDX_W-1:0] REG_BACK_RED   = 3'd3;
	localparam logic [IDX_W-1:0] REG_BACK_GREEN = 3'd4;
	localparam logic [IDX_W-1:0] REG_BACK_BLUE  = 3'd5;
	localparam logic [IDX_W-1:0] REG_ALPHA_MODE = 3'd6;

	localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;
	localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'h00;
	localparam logic [NUM_W-1:0]  BLEND_RND = 16'd127;

	typedef enum logic [1:0] {
		SEL_TINT,
		SEL_BACK,
		SEL_BLEND
	} sel_t;

	// stage load strobes shared by every lane
	typedef struct packed {
		logic ld1;
		logic ld2;
		logic ld3;
	} lane_ctl_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} lane_res_t;

endpackage

// ===== sv/duotone_pixel_recolor_top.sv =====
// duotone pixel recolor: three channel lanes side by side, then a merge register
// an accepted input word moves through stages 1, 2 and 3 and then the merge register to output
// throughput: one word per cycle unless m_tready stalls the output; stages advance on their own so bubbles fill
// reset: arst_n clears all valid bits, colours to zero and alpha mode to on
// depends on dpr_pkg, dpr_lane, dpr_merge
module duotone_pixel_recolor_top import dpr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [7:0]       cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,  // src_blue, src_green, src_red, src_alpha
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata   // out_blue, out_green, out_red, out_alpha
);

	logic [CHAN_W-1:0] fore_red_q, fore_green_q, fore_blue_q;
	logic [CHAN_W-1:0] back_red_q, back_green_q, back_blue_q;
	logic              alpha_mode_q;

	logic      v1_q, v2_q, v3_q;
	logic      cap2, cap3, cap4;
	logic      ld4;
	lane_ctl_t ctl;
	lane_res_t res;
	sel_t      sel;
	logic [CHAN_W-1:0] alpha;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_red_q   <= CHAN_ZERO;
			fore_green_q <= CHAN_ZERO;
			fore_blue_q  <= CHAN_ZERO;
			back_red_q   <= CHAN_ZERO;
			back_green_q <= CHAN_ZERO;
			back_blue_q  <= CHAN_ZERO;
			alpha_mode_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FORE_RED:   fore_red_q   <= cfg_data;
				REG_FORE_GREEN: fore_green_q <= cfg_data;
				REG_FORE_BLUE:  fore_blue_q  <= cfg_data;
				REG_BACK_RED:   back_red_q   <= cfg_data;
				REG_BACK_GREEN: back_green_q <= cfg_data;
				REG_BACK_BLUE:  back_blue_q  <= cfg_data;
				REG_ALPHA_MODE: alpha_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// a stage can take a word when it is empty or its word moves on
	assign cap3     = !v3_q || cap4;
	assign cap2     = !v2_q || cap3;
	assign s_tready = !v1_q || cap2;
	assign ctl.ld1  = s_tvalid && s_tready;
	assign ctl.ld2  = v1_q && cap2;
	assign ctl.ld3  = v2_q && cap3;
	assign ld4      = v3_q && cap4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			v1_q <= ctl.ld1 || (v1_q && !ctl.ld2);
			v2_q <= ctl.ld2 || (v2_q && !ctl.ld3);
			v3_q <= ctl.ld3 || (v3_q && !ld4);
		end
	end

	assign alpha = s_tdata[31:24];

	always_comb begin
		if (!alpha_mode_q || alpha == CHAN_FULL) begin
			sel = SEL_TINT;
		end else if (alpha == CHAN_ZERO) begin
			sel = SEL_BACK;
		end else begin
			sel = SEL_BLEND;
		end
	end

	dpr_lane u_lane_blue (
		.clk   (clk),
		.ctl   (ctl),
		.src   (s_tdata[7:0]),
		.alpha (alpha),
		.sel   (sel),
		.fg    (fore_blue_q),
		.bg    (back_blue_q),
		.res   (res.blue)
	);

	dpr_lane u_lane_green (
		.clk   (clk),
		.ctl   (ctl),
		.src   (s_tdata[15:8]),
		.alpha (alpha),
		.sel   (sel),
		.fg    (fore_green_q),
		.bg    (back_green_q),
		.res   (res.green)
	);

	dpr_lane u_lane_red (
		.clk   (clk),
		.ctl   (ctl),
		.src   (s_tdata[23:16]),
		.alpha (alpha),
		.sel   (sel),
		.fg    (fore_red_q),
		.bg    (back_red_q),
		.res   (res.red)
	);

	dpr_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ld4),
		.lanes    (res),
		.cap      (cap4),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v1_q)
		else $error("accepted word not held in first stage");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v1_q && v2_q && v3_q && m_tvalid && !m_tready))
		else $error("input stalled with room in the pipeline");

	a_out_alpha_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[31:24] == CHAN_FULL))
		else $error("output alpha not opaque");

	a_s3_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_q && !m_tvalid) |=> m_tvalid)
		else $error("last stage word not moved to output");
`endif

endmodule

// ===== sv/dpr_lane.sv =====
// one colour channel: tint, blend numerator and divide by 255
// depends on dpr_pkg
module dpr_lane import dpr_pkg::*; (
	input  logic              clk,
	input  lane_ctl_t         ctl,
	input  logic [CHAN_W-1:0] src,
	input  logic [CHAN_W-1:0] alpha,
	input  sel_t              sel,
	input  logic [CHAN_W-1:0] fg,
	input  logic [CHAN_W-1:0] bg,
	output logic [CHAN_W-1:0] res
);

	logic signed [CHAN_W:0]     diff;
	logic signed [CHAN_W:0]     inv;
	logic signed [2*CHAN_W+1:0] prod;
	logic signed [PROD_W-1:0]   p_s1;
	logic [CHAN_W-1:0]          a_s1;
	sel_t                       sel_s1;

	logic signed [PROD_W-9:0]   q;
	logic signed [CHAN_W+1:0]   t_full;
	logic [CHAN_W-1:0]          t_s2;
	logic [CHAN_W-1:0]          a_s2;
	sel_t                       sel_s2;

	logic [NUM_W-1:0]           num;
	logic [NUM_W-1:0]           num_s3;
	logic [CHAN_W-1:0]          t_s3;
	sel_t                       sel_s3;
	logic [NUM_W:0]             div_sum;

	assign diff = $signed({1'b0, fg}) - $signed({1'b0, bg});
	assign inv  = $signed({1'b0, CHAN_FULL - src});
	assign prod = diff * inv;

	always_ff @(posedge clk) begin
		if (ctl.ld1) begin
			p_s1   <= prod[PROD_W-1:0];
			a_s1   <= alpha;
			sel_s1 <= sel;
		end
	end

	// arithmetic shift floors towards minus infinity
	assign q      = p_s1[PROD_W-1:8];
	assign t_full = $signed({2'b00, fg}) - $signed({q[PROD_W-9], q});

	always_ff @(posedge clk) begin
		if (ctl.ld2) begin
			t_s2   <= t_full[CHAN_W-1:0];
			a_s2   <= a_s1;
			sel_s2 <= sel_s1;
		end
	end

	assign num = NUM_W'(t_s2 * a_s2) + NUM_W'((CHAN_FULL - a_s2) * bg) + BLEND_RND;

	always_ff @(posedge clk) begin
		if (ctl.ld3) begin
			num_s3 <= num;
			t_s3   <= t_s2;
			sel_s3 <= sel_s2;
		end
	end

	// x / 255 as (x + 1 + (x >> 8)) >> 8, exact over the numerator range
	assign div_sum = {1'b0, num_s3} + (NUM_W+1)'(1) + {9'd0, num_s3[NUM_W-1:8]};

	always_comb begin
		case (sel_s3)
			SEL_TINT:  res = t_s3;
			SEL_BACK:  res = bg;
			SEL_BLEND: res = div_sum[NUM_W-1:8];
			default:   res = t_s3;
		endcase
	end

endmodule

// ===== sv/dpr_merge.sv =====
// merges the three lane results into one output word with its register
// depends on dpr_pkg
module dpr_merge import dpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ld,
	input  lane_res_t   lanes,
	output logic        cap,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata
);

	logic        valid_q;
	logic [31:0] data_q;

	assign cap = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ld || (valid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			data_q <= {CHAN_FULL, lanes.red, lanes.green, lanes.blue};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule
